// ===== rtl/core/itrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_pkg
// shared constants, widths and the digit-to-ascii mapping for the
// integer-to-radix-text converter
// ----------------------------------------------------------------------------
package itrt_pkg;

	localparam int NUM_W   = 32;  // width of the number port
	localparam int RADIX_W = 8;   // width of the radix port
	localparam int CHAR_W  = 7;   // ascii character width
	localparam int REM_W   = 6;   // remainder / digit width, holds 0..34
	localparam int STEP_BITS = 8; // dividend bits consumed per divider cycle

	localparam logic [RADIX_W-1:0] MIN_RADIX = 8'd2;
	localparam logic [RADIX_W-1:0] MAX_RADIX = 8'd35;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2d;
	localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
	localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h61;
	localparam logic [CHAR_W-1:0] NUL_CHAR   = 7'h00;

	typedef logic [REM_W-1:0] digit_t;

	// digit value to lower-case ascii: 0..9 then a..z
	function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
		logic [CHAR_W-1:0] c;
		if (d < REM_W'(10)) begin
			c = ZERO_CHAR + CHAR_W'(d);
		end else begin
			c = ALPHA_CHAR + CHAR_W'(d) - CHAR_W'(10);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/itrt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module itrt_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/itrt_divstep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_divstep
// restoring division slice: folds one chunk of dividend bits into a narrow
// remainder against a small divisor, producing the matching quotient bits
// ----------------------------------------------------------------------------
module itrt_divstep (
	input  wire logic [itrt_pkg::REM_W-1:0]     rem_in,
	input  wire logic [itrt_pkg::STEP_BITS-1:0] bits_in,
	input  wire logic [itrt_pkg::REM_W-1:0]     divisor,
	output      logic [itrt_pkg::REM_W-1:0]     rem_out,
	output      logic [itrt_pkg::STEP_BITS-1:0] quo_bits
);

	import itrt_pkg::*;

	// remainder stays below the divisor, so 2r+1 fits one extra bit
	always_comb begin
		logic [REM_W:0] r;
		r = {1'b0, rem_in};
		quo_bits = '0;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			r = {r[REM_W-1:0], bits_in[i]};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
				quo_bits[i] = 1'b1;
			end
		end
		rem_out = r[REM_W-1:0];
	end

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_radix_text_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// signed integer to base-n ascii text, one character per result transfer,
// most significant character first, leading '-' for negative values
// ----------------------------------------------------------------------------
// an invalid radix gives its single empty result in the cycle after start.
// a valid item runs one division pass per digit, lsd first, each pass taking
// C = ceil(VALUE_BITS/8) chunks through the shared 8-bit divider slice, then
// one head step for the sign or ram prime, then one character per cycle, msd
// first. busy drops as the last character is registered, so the next start
// can land on the edge of the last transfer.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command side
	input  wire logic                                start,
	output      logic                                busy,
	input  wire logic signed [itrt_pkg::NUM_W-1:0]   number,
	input  wire logic [itrt_pkg::RADIX_W-1:0]        radix,
	// result side
	output      logic                                strobe,
	output      logic [itrt_pkg::CHAR_W-1:0]         text_char,
	output      logic                                last_char,
	output      logic                                empty_text
);

	import itrt_pkg::*;

	// dividend is padded up to whole chunks for the divider slice
	localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W  = CHUNKS * STEP_BITS;
	localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int AW     = $clog2(VALUE_BITS);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0; // waiting for a start transfer
	localparam logic [1:0] ST_DIV  = 2'd1; // peeling digits, lsd first
	localparam logic [1:0] ST_HEAD = 2'd2; // '-' (if negative) and ram prime
	localparam logic [1:0] ST_EMIT = 2'd3; // digits out, msd first

	logic [1:0]         state_q;
	logic               neg_q;
	digit_t             radix_q;
	logic [DIV_W-1:0]   quo_q;      // dividend, shifts into quotient in place
	digit_t             rem_q;
	logic [CNT_W-1:0]   chunk_q;
	logic [AW-1:0]      ndig_q;     // ram slot for the digit being built
	logic [AW-1:0]      ptr_q;      // ram slot for the digit being emitted

	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               empty_q;

	// input decode
	logic signed [63:0]    num_ext;
	logic [VALUE_BITS-1:0] raw;
	logic                  raw_neg;
	logic [VALUE_BITS-1:0] mag;
	logic                  radix_ok;
	logic                  accept;

	// shared divider slice
	digit_t                rem_n;
	logic [STEP_BITS-1:0]  qbits;
	logic [DIV_W-1:0]      quo_n;
	logic                  last_chunk;

	// digit stack
	logic                  ram_we;
	logic [AW-1:0]         rd_addr;
	digit_t                rd_digit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// only the low VALUE_BITS bits count, read as two's complement
	assign num_ext  = 64'(number);
	assign raw      = num_ext[VALUE_BITS-1:0];
	assign raw_neg  = raw[VALUE_BITS-1];
	// most negative value negates to its own pattern, which is the right
	// unsigned magnitude
	assign mag      = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;
	assign radix_ok = (radix >= MIN_RADIX) && (radix <= MAX_RADIX);

	itrt_divstep u_divstep (
		.rem_in   (rem_q),
		.bits_in  (quo_q[DIV_W-1 -: STEP_BITS]),
		.divisor  (radix_q),
		.rem_out  (rem_n),
		.quo_bits (qbits)
	);

	// after the last chunk the register holds the whole quotient
	generate
		if (CHUNKS > 1) begin : g_multi
			assign quo_n = {quo_q[DIV_W-STEP_BITS-1:0], qbits};
		end else begin : g_single
			assign quo_n = qbits;
		end
	endgenerate

	assign last_chunk = (chunk_q == CNT_W'(CHUNKS - 1));
	assign ram_we     = (state_q == ST_DIV) && last_chunk;

	// read address runs one step ahead of ptr_q while emitting so the
	// registered read data lines up with the digit being sent
	assign rd_addr = (state_q == ST_EMIT) ? (ptr_q - AW'(1)) : ptr_q;

	itrt_ram #(
		.WIDTH (REM_W),
		.DEPTH (VALUE_BITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ndig_q),
		.wdata (rem_n),
		.raddr (rd_addr),
		.rdata (rd_digit)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && radix_ok) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_chunk && (quo_n == '0)) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q   <= raw_neg;
					radix_q <= radix[REM_W-1:0];
					quo_q   <= DIV_W'(mag);
					rem_q   <= '0;
					chunk_q <= '0;
					ndig_q  <= '0;
				end
			end
			ST_DIV: begin
				quo_q <= quo_n;
				if (last_chunk) begin
					// digit done: restart the remainder for the next one
					rem_q   <= '0;
					chunk_q <= '0;
					ndig_q  <= ndig_q + AW'(1);
					ptr_q   <= ndig_q;
				end else begin
					rem_q   <= rem_n;
					chunk_q <= chunk_q + CNT_W'(1);
				end
			end
			ST_EMIT: begin
				ptr_q <= ptr_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	// result register: one transfer per strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (accept && !radix_ok)
				|| ((state_q == ST_HEAD) && neg_q)
				|| (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !radix_ok) begin
			// bad radix stands for the empty string
			char_q  <= NUL_CHAR;
			last_q  <= 1'b1;
			empty_q <= 1'b1;
		end else if (state_q == ST_HEAD) begin
			char_q  <= MINUS_CHAR;
			last_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			char_q  <= digit_char(rd_digit);
			last_q  <= (ptr_q == '0);
			empty_q <= 1'b0;
		end
	end

	assign strobe     = strobe_q;
	assign text_char  = char_q;
	assign last_char  = last_q;
	assign empty_text = empty_q;

endmodule
`default_nettype wire
